>>> hdl/mmpid_pkg.sv
// Package for the multi-motor PID speed controller.
// Holds sequencer states, datapath widths, register indexes and reset values.
// No dependencies.
package mmpid_pkg;

  // Default number of motor channels with their own PID state
  localparam int MOTOR_COUNT_DEF = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP          = 3'd0,
    CFG_KI_DT       = 3'd1,
    CFG_KD_OVER_DT  = 3'd2,
    CFG_SPEED_SCALE = 3'd3,
    CFG_DUTY_FS     = 3'd4
  } cfg_reg_t;

  localparam logic [23:0] SPEED_SCALE_RST = 24'd1638400;
  localparam logic [7:0]  DUTY_FS_RST     = 8'd255;

  // Datapath widths
  localparam int MUL_A_W = 34;                 // count, error, speed diff or |duty|
  localparam int MUL_B_W = 25;                 // gain, scale, fs or 16-bit kd half
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ERR_W   = 33;
  localparam int TMP_W   = 50;                 // low half product of the derivative
  localparam int ACC_W   = 52;                 // p + d accumulator
  localparam int DUTY_W  = ACC_W + 1;
  localparam int MAG_W   = 17;                 // |duty| up to 65536

  localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'(65536);
  localparam logic signed [DUTY_W-1:0] DUTY_MIN = -DUTY_W'(65536);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RPS,
    S_ERR,
    S_P,
    S_I,
    S_DLO,
    S_DHI,
    S_SUM,
    S_SCL
  } state_t;

endpackage

>>> hdl/multi_motor_pid_speed_control.sv
// Multi-motor PID speed controller, top level.
// Uses mmpid_pkg for states, widths, register indexes and reset values.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat carries a motor index, the
//    encoder count of one control period and a speed setpoint (Q12.16 rps).
//  - Result channel (out_valid / out_stall): one beat per input beat with the
//    echoed channel, forward and reverse PWM levels, the signed drive and the
//    measured speed (Q16.16 rps).
//  - Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 kp,
//    1 ki_dt, 2 kd_over_dt, 3 speed_scale, 4 duty_full_scale); other indexes
//    are dropped. Write only while no beat is in flight.
//  - Sequencing: one shared 34x25 multiplier runs six passes per item (speed,
//    P, I, two halves of D, PWM scaling) plus error and sum/clamp steps; the
//    result is loaded into the output register from the scaling step, and the
//    next beat is accepted once the sequencer is back in idle.
//  - in_stall is high while the sequencer works on an item. A finished result
//    waits in the output register; a new beat is accepted meanwhile, and the
//    sequencer holds in its last step while the previous result is stalled.
//  - Synchronous reset clears gains, the per-motor integral and previous
//    speed of every channel, and the output valid.
//  - Channels at or beyond MOTOR_COUNT compute from zero state and leave all
//    state untouched.
module multi_motor_pid_speed_control #(
  parameter int MOTOR_COUNT = mmpid_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmpid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_motor_index,
  input  logic signed [15:0]                  in_encoder_count,
  input  logic signed [27:0]                  in_target_speed,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_motor_channel,
  output logic [7:0]                          out_forward_level,
  output logic [7:0]                          out_reverse_level,
  output logic signed [8:0]                   out_signed_drive,
  output logic signed [31:0]                  out_measured_speed
);

  localparam int IDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int MUL_A_W = mmpid_pkg::MUL_A_W;
  localparam int MUL_B_W = mmpid_pkg::MUL_B_W;
  localparam int PROD_W  = mmpid_pkg::PROD_W;
  localparam int ERR_W   = mmpid_pkg::ERR_W;
  localparam int TMP_W   = mmpid_pkg::TMP_W;
  localparam int ACC_W   = mmpid_pkg::ACC_W;
  localparam int DUTY_W  = mmpid_pkg::DUTY_W;
  localparam int MAG_W   = mmpid_pkg::MAG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [23:0] kp_r;
  logic signed [23:0] ki_r;
  logic signed [31:0] kd_r;
  logic [23:0]        scale_r;
  logic [7:0]         fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      scale_r <= mmpid_pkg::SPEED_SCALE_RST;
      fs_r    <= mmpid_pkg::DUTY_FS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mmpid_pkg::CFG_KP:          kp_r    <= cfg_wdata[23:0];
        mmpid_pkg::CFG_KI_DT:       ki_r    <= cfg_wdata[23:0];
        mmpid_pkg::CFG_KD_OVER_DT:  kd_r    <= cfg_wdata[31:0];
        mmpid_pkg::CFG_SPEED_SCALE: scale_r <= cfg_wdata[23:0];
        mmpid_pkg::CFG_DUTY_FS:     fs_r    <= cfg_wdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  mmpid_pkg::state_t state_r, state_nxt;
  logic              out_valid_r;

  logic in_fire;
  logic out_free;

  assign in_stall = (state_r != mmpid_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmpid_pkg::S_IDLE: if (in_fire) state_nxt = mmpid_pkg::S_RPS;
      mmpid_pkg::S_RPS:  state_nxt = mmpid_pkg::S_ERR;
      mmpid_pkg::S_ERR:  state_nxt = mmpid_pkg::S_P;
      mmpid_pkg::S_P:    state_nxt = mmpid_pkg::S_I;
      mmpid_pkg::S_I:    state_nxt = mmpid_pkg::S_DLO;
      mmpid_pkg::S_DLO:  state_nxt = mmpid_pkg::S_DHI;
      mmpid_pkg::S_DHI:  state_nxt = mmpid_pkg::S_SUM;
      mmpid_pkg::S_SUM:  state_nxt = mmpid_pkg::S_SCL;
      mmpid_pkg::S_SCL:  if (out_free) state_nxt = mmpid_pkg::S_IDLE;
      default:           state_nxt = mmpid_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmpid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Item registers and per-motor state
  // ---------------------------------------------------------------------------
  logic [1:0]                ch_r;
  logic                      ch_ok_r;     // channel owns state
  logic [IDX_W-1:0]          idx_r;
  logic signed [15:0]        cnt_r;
  logic signed [27:0]        tgt_r;
  logic signed [31:0]        integ_r;
  logic signed [31:0]        prev_r;
  logic signed [31:0]        rps_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [ERR_W-1:0]   dif_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [TMP_W-1:0]   tmp_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;

  logic signed [31:0] integ_mem_r [MOTOR_COUNT];
  logic signed [31:0] prev_mem_r  [MOTOR_COUNT];

  logic             in_ok;
  logic [IDX_W-1:0] in_idx;

  assign in_ok  = (32'(in_motor_index) < MOTOR_COUNT);
  assign in_idx = IDX_W'(in_motor_index);

  // ---------------------------------------------------------------------------
  // Shared multiplier and its operand select
  // ---------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mmpid_pkg::S_RPS: begin
        mul_a = {{(MUL_A_W-16){cnt_r[15]}}, cnt_r};
        mul_b = {{(MUL_B_W-24){1'b0}}, scale_r};
      end
      mmpid_pkg::S_P: begin
        mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-24){kp_r[23]}}, kp_r};
      end
      mmpid_pkg::S_I: begin
        mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-24){ki_r[23]}}, ki_r};
      end
      mmpid_pkg::S_DLO: begin
        // low half of kd taken as unsigned
        mul_a = {{(MUL_A_W-ERR_W){dif_r[ERR_W-1]}}, dif_r};
        mul_b = {{(MUL_B_W-16){1'b0}}, kd_r[15:0]};
      end
      mmpid_pkg::S_DHI: begin
        mul_a = {{(MUL_A_W-ERR_W){dif_r[ERR_W-1]}}, dif_r};
        mul_b = {{(MUL_B_W-16){kd_r[31]}}, kd_r[31:16]};
      end
      mmpid_pkg::S_SCL: begin
        mul_a = {{(MUL_A_W-MAG_W){1'b0}}, mag_r};
        mul_b = {{(MUL_B_W-8){1'b0}}, fs_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Per-step arithmetic around the multiplier
  // ---------------------------------------------------------------------------
  logic signed [43:0]       isum;       // integral plus increment, before saturation
  logic signed [31:0]       isat;
  logic signed [ACC_W-1:0]  p_term;
  logic signed [ACC_W-1:0]  d_acc;
  logic signed [DUTY_W-1:0] duty;
  logic signed [DUTY_W-1:0] duty_neg;
  logic [MAG_W-1:0]         mag_nxt;
  logic                     neg_nxt;
  logic [7:0]               drv;

  always_comb begin
    isum = {{12{integ_r[31]}}, integ_r} + {prod[PROD_W-1], prod[PROD_W-1:16]};
    if (isum[43:31] != {13{isum[43]}}) begin
      // saturate toward the sign of the sum
      isat = isum[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      isat = isum[31:0];
    end

    p_term = {{(ACC_W-(PROD_W-16)){prod[PROD_W-1]}}, prod[PROD_W-1:16]};

    // d = kd_hi*dif + floor(kd_lo*dif / 2^16), added to p
    d_acc = acc_r + prod[ACC_W-1:0]
          + {{(ACC_W-(TMP_W-16)){tmp_r[TMP_W-1]}}, tmp_r[TMP_W-1:16]};

    duty     = {acc_r[ACC_W-1], acc_r} + {{(DUTY_W-32){integ_r[31]}}, integ_r};
    duty_neg = -duty;
    if (duty > mmpid_pkg::DUTY_MAX) begin
      mag_nxt = MAG_W'(65536);
      neg_nxt = 1'b0;
    end else if (duty < mmpid_pkg::DUTY_MIN) begin
      mag_nxt = MAG_W'(65536);
      neg_nxt = 1'b1;
    end else begin
      neg_nxt = duty[DUTY_W-1];
      mag_nxt = neg_nxt ? duty_neg[MAG_W-1:0] : duty[MAG_W-1:0];
    end

    drv = prod[23:16];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mmpid_pkg::S_IDLE: begin
        if (in_fire) begin
          ch_r    <= in_motor_index;
          ch_ok_r <= in_ok;
          idx_r   <= in_idx;
          cnt_r   <= in_encoder_count;
          tgt_r   <= in_target_speed;
          integ_r <= in_ok ? integ_mem_r[in_idx] : 32'sd0;
          prev_r  <= in_ok ? prev_mem_r[in_idx] : 32'sd0;
        end
      end
      mmpid_pkg::S_RPS: rps_r <= prod[39:8];
      mmpid_pkg::S_ERR: begin
        err_r <= {{(ERR_W-28){tgt_r[27]}}, tgt_r} - {rps_r[31], rps_r};
        dif_r <= {rps_r[31], rps_r} - {prev_r[31], prev_r};
      end
      mmpid_pkg::S_P:   acc_r   <= p_term;
      mmpid_pkg::S_I:   integ_r <= isat;
      mmpid_pkg::S_DLO: tmp_r   <= prod[TMP_W-1:0];
      mmpid_pkg::S_DHI: acc_r   <= d_acc;
      mmpid_pkg::S_SUM: begin
        mag_r <= mag_nxt;
        neg_r <= neg_nxt;
      end
      default: ;
    endcase
  end

  // Write back integral and speed once both are final
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        integ_mem_r[i] <= '0;
        prev_mem_r[i]  <= '0;
      end
    end else if (state_r == mmpid_pkg::S_SUM && ch_ok_r) begin
      integ_mem_r[idx_r] <= integ_r;
      prev_mem_r[idx_r]  <= rps_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [1:0]         out_ch_r;
  logic [7:0]         out_fwd_r;
  logic [7:0]         out_rev_r;
  logic signed [8:0]  out_drive_r;
  logic signed [31:0] out_speed_r;
  logic               out_load;

  assign out_load = (state_r == mmpid_pkg::S_SCL) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_fwd_r   <= neg_r ? 8'd0 : drv;
      out_rev_r   <= neg_r ? drv : 8'd0;
      out_drive_r <= neg_r ? -$signed({1'b0, drv}) : $signed({1'b0, drv});
      out_speed_r <= rps_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_channel  = out_ch_r;
  assign out_forward_level  = out_fwd_r;
  assign out_reverse_level  = out_rev_r;
  assign out_signed_drive   = out_drive_r;
  assign out_measured_speed = out_speed_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == mmpid_pkg::S_RPS)
    else $error("accepted beat did not start the sequencer");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == mmpid_pkg::S_SCL)
    else $error("result appeared outside the scaling step");

  a_one_side_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fwd_r == 8'd0 || out_rev_r == 8'd0))
    else $error("both bridge inputs driven");

  a_drive_within_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fwd_r <= fs_r && out_rev_r <= fs_r))
    else $error("drive level beyond full scale");

  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmpid_pkg::S_SCL |-> mag_r <= MAG_W'(65536))
    else $error("duty magnitude beyond clamp");

endmodule

>>> tb/mmpid_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multi-motor PID speed controller: watches the config port and
// both channels, predicts each result beat and compares it. Depends on mmpid_pkg.
module mmpid_checker #(
  parameter int MOTOR_COUNT = mmpid_pkg::MOTOR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmpid_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_motor_index,
  input  logic signed [15:0]               in_encoder_count,
  input  logic signed [27:0]               in_target_speed,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [1:0]                       out_motor_channel,
  input  logic [7:0]                       out_forward_level,
  input  logic [7:0]                       out_reverse_level,
  input  logic signed [8:0]                out_signed_drive,
  input  logic signed [31:0]               out_measured_speed,
  output int                               mismatch_count,
  output int                               outstanding
);

  typedef struct packed {
    logic [1:0]         channel;
    logic [7:0]         fwd;
    logic [7:0]         rev;
    logic signed [8:0]  drive;
    logic signed [31:0] speed;
  } drive_beat_t;

  logic signed [23:0] kp_q;
  logic signed [23:0] ki_dt_q;
  logic signed [31:0] kd_q;
  logic [23:0]        scale_q;
  logic [7:0]         full_scale_q;
  longint             integ_q    [MOTOR_COUNT];
  longint             prev_rps_q [MOTOR_COUNT];

  drive_beat_t drive_expect_q[$];

  // Advance one motor's PID loop and return the beat it should produce.
  function automatic drive_beat_t run_speed_loop(logic [1:0] ch, logic signed [15:0] count,
                                                 logic signed [27:0] target);
    longint      rps, err, p, d, integ, prev, duty, mag, drive;
    bit          own;
    drive_beat_t r;
    own   = (int'(ch) < MOTOR_COUNT);
    integ = own ? integ_q[ch] : 0;
    prev  = own ? prev_rps_q[ch] : 0;
    rps   = (longint'(count) * longint'(scale_q)) >>> 8;
    err   = longint'(target) - rps;
    p     = (longint'(kp_q) * err) >>> 16;
    integ = integ + ((longint'(ki_dt_q) * err) >>> 16);
    if (integ > 64'sd2147483647) integ = 64'sd2147483647;
    if (integ < -64'sd2147483648) integ = -64'sd2147483648;
    d     = (longint'(kd_q) * (rps - prev)) >>> 16;
    duty  = p + integ + d;
    if (duty > 65536) duty = 65536;
    if (duty < -65536) duty = -65536;
    mag   = (duty < 0) ? -duty : duty;
    mag   = (mag * longint'(full_scale_q)) >>> 16;
    drive = (duty < 0) ? -mag : mag;
    if (own) begin
      integ_q[ch]    = integ;
      prev_rps_q[ch] = rps;
    end
    r.channel = ch;
    r.fwd     = (drive > 0) ? 8'(drive) : 8'd0;
    r.rev     = (drive > 0) ? 8'd0 : 8'(-drive);
    r.drive   = 9'(drive);
    r.speed   = 32'(rps);
    return r;
  endfunction

  always @(posedge clk) begin
    drive_beat_t want, got;
    if (!rst_n) begin
      kp_q           = '0;
      ki_dt_q        = '0;
      kd_q           = '0;
      scale_q        = mmpid_pkg::SPEED_SCALE_RST;
      full_scale_q   = mmpid_pkg::DUTY_FS_RST;
      mismatch_count = 0;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        integ_q[m]    = 0;
        prev_rps_q[m] = 0;
      end
      drive_expect_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (mmpid_pkg::cfg_reg_t'(cfg_index))
          mmpid_pkg::CFG_KP:          kp_q         = cfg_wdata[23:0];
          mmpid_pkg::CFG_KI_DT:       ki_dt_q      = cfg_wdata[23:0];
          mmpid_pkg::CFG_KD_OVER_DT:  kd_q         = cfg_wdata[31:0];
          mmpid_pkg::CFG_SPEED_SCALE: scale_q      = cfg_wdata[23:0];
          mmpid_pkg::CFG_DUTY_FS:     full_scale_q = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        drive_expect_q.push_back(run_speed_loop(in_motor_index, in_encoder_count,
                                                in_target_speed));
      if (out_valid && !out_stall) begin
        got = '{out_motor_channel, out_forward_level, out_reverse_level,
                out_signed_drive, out_measured_speed};
        if (drive_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result beat ch=%0d fwd=%0d rev=%0d drive=%0d speed=%0d",
                     $realtime, got.channel, got.fwd, got.rev, got.drive, got.speed);
        end else begin
          want = drive_expect_q.pop_front();
          if (got.channel !== want.channel || got.fwd !== want.fwd ||
              got.rev !== want.rev || got.drive !== want.drive ||
              got.speed !== want.speed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: result mismatch exp ch=%0d fwd=%0d rev=%0d drive=%0d ",
                        "speed=%0d, got ch=%0d fwd=%0d rev=%0d drive=%0d speed=%0d"},
                       $realtime, want.channel, want.fwd, want.rev, want.drive,
                       want.speed, got.channel, got.fwd, got.rev, got.drive,
                       got.speed);
          end
        end
      end
    end
    outstanding <= drive_expect_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the multi-motor PID speed controller: clock, reset, stimulus,
// result sink and verdict. Depends on mmpid_pkg, the block and mmpid_checker.
module tb;

  // Per-phase random beat count; eight phases give roughly 1850 beats.
  localparam int RANDOM_PER_PHASE = 232;
  localparam int HOLD_OFF_CYCLES  = 400;
  // Register indexes past the last real register; writes there must be dropped.
  localparam int CFG_SPARE_LO     = int'(mmpid_pkg::CFG_DUTY_FS) + 1;
  localparam int CFG_SPARE_HI     = (1 << mmpid_pkg::CFG_IDX_W) - 1;
  localparam longint TARGET_MAX   = 134217727;
  localparam longint TARGET_MIN   = -134217728;
  localparam logic [15:0] COUNT_CORNERS  [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
  localparam logic [27:0] TARGET_CORNERS [4] = '{28'h8000000, 28'h7FFFFFF, 28'h0000000,
                                                 28'hFFFFFFF};

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [mmpid_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mmpid_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       in_motor_index;
  logic signed [15:0]               in_encoder_count;
  logic signed [27:0]               in_target_speed;
  logic                             out_valid;
  logic                             out_stall;
  logic [1:0]                       out_motor_channel;
  logic [7:0]                       out_forward_level;
  logic [7:0]                       out_reverse_level;
  logic signed [8:0]                out_signed_drive;
  logic signed [31:0]               out_measured_speed;

  int mismatch_count;
  int outstanding;

  // Shared between the sender and the sink: calm turns idling off on both sides,
  // hold_off_req asks the sink for one long stall.
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  // Speed scale currently loaded; used only to aim setpoints near the measured speed.
  logic [23:0] scale_now = mmpid_pkg::SPEED_SCALE_RST;

  multi_motor_pid_speed_control #(
    .MOTOR_COUNT(mmpid_pkg::MOTOR_COUNT_DEF)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_motor_index     (in_motor_index),
    .in_encoder_count   (in_encoder_count),
    .in_target_speed    (in_target_speed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_channel  (out_motor_channel),
    .out_forward_level  (out_forward_level),
    .out_reverse_level  (out_reverse_level),
    .out_signed_drive   (out_signed_drive),
    .out_measured_speed (out_measured_speed)
  );

  mmpid_checker #(
    .MOTOR_COUNT(mmpid_pkg::MOTOR_COUNT_DEF)
  ) u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_motor_index     (in_motor_index),
    .in_encoder_count   (in_encoder_count),
    .in_target_speed    (in_target_speed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_channel  (out_motor_channel),
    .out_forward_level  (out_forward_level),
    .out_reverse_level  (out_reverse_level),
    .out_signed_drive   (out_signed_drive),
    .out_measured_speed (out_measured_speed),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Symmetric random value in [-half, half].
  function automatic int signed_spread(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // Result sink: random stalls, plus one long hold-off on request so that the
  // output register and the sequencer both fill and the input stalls.
  initial begin : result_sink
    int n;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        n = HOLD_OFF_CYCLES;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 8)) @(posedge clk);
    end
  end

  // One register write; the enable drops the cycle after.
  task automatic write_reg(input logic [mmpid_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [mmpid_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Load all five registers; fill unused high bits with junk, which must be
  // ignored, and poke one index past the register list.
  task automatic load_gains(input logic [23:0] kp, input logic [23:0] ki,
                            input logic [31:0] kd, input logic [23:0] scale,
                            input logic [7:0] full_scale);
    write_reg(mmpid_pkg::CFG_KP,          {8'($urandom), kp});
    write_reg(mmpid_pkg::CFG_KI_DT,       {8'($urandom), ki});
    write_reg(mmpid_pkg::CFG_KD_OVER_DT,  kd);
    write_reg(mmpid_pkg::CFG_SPEED_SCALE, {8'($urandom), scale});
    write_reg(mmpid_pkg::CFG_DUTY_FS,     {24'($urandom), full_scale});
    write_reg(mmpid_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
    scale_now = scale;
  endtask

  // Offer one beat and hold it until accepted; then drop valid and idle for gap.
  // With gap 0 valid stays high and the next call simply updates the payload.
  task automatic send_sample(input logic [1:0] motor, input logic [15:0] count,
                             input logic [27:0] target, input int gap);
    in_valid         <= 1'b1;
    in_motor_index   <= motor;
    in_encoder_count <= count;
    in_target_speed  <= target;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random beat: mostly a setpoint close to the measured speed, so the loop
  // stays out of the clamp; the rest full-range noise and field corners.
  task automatic send_random_sample(input int gap);
    int          pick;
    int          c;
    longint      aim;
    logic [15:0] count;
    logic [27:0] target;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      c     = signed_spread(400);
      count = 16'(c);
      aim   = (longint'(c) * longint'(scale_now)) >>> 8;
      aim   = aim + longint'(signed_spread(1 << 17));
      if (aim > TARGET_MAX) aim = TARGET_MAX;
      if (aim < TARGET_MIN) aim = TARGET_MIN;
      target = 28'(aim);
    end else if (pick < 85) begin
      count  = 16'($urandom);
      target = 28'($urandom);
    end else begin
      count  = COUNT_CORNERS[$urandom_range(0, 3)];
      target = TARGET_CORNERS[$urandom_range(0, 3)];
    end
    send_sample(2'($urandom_range(0, 3)), count, target, gap);
  endtask

  // Drop valid and wait until every expected result beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    logic [23:0] kp, ki, scale;
    logic [31:0] kd;
    logic [7:0]  full_scale;
    int          ph;
    int          k;
    int          gap;

    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_motor_index   <= '0;
    in_encoder_count <= '0;
    in_target_speed  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unity P, small I and D, default scale and full PWM range.
    load_gains(24'h010000, 24'h000400, 32'h0000_2000, mmpid_pkg::SPEED_SCALE_RST,
               mmpid_pkg::DUTY_FS_RST);
    send_sample(2'd0, 16'h0000, 28'h0000000, idle_len());     // zero error, zero drive
    send_sample(2'd1, 16'h7FFF, 28'h7FFFFFF, idle_len());     // both fields at max
    send_sample(2'd2, 16'h8000, 28'h8000000, idle_len());     // both fields at min
    send_sample(2'd3, 16'h7FFF, 28'h8000000, idle_len());     // largest negative error
    send_sample(2'd0, 16'h8000, 28'h7FFFFFF, idle_len());     // largest positive error
    send_sample(2'd1, 16'd100,  28'(640050), idle_len());     // small error; motor 1 history clamps duty negative
    send_sample(2'd2, 16'd10,   28'(-6000), idle_len());      // motor 2 history clamps duty positive
    send_sample(2'd3, 16'hFFFF, 28'hFFFFFFF, idle_len());
    send_sample(2'd0, 16'h0001, 28'h0000001, idle_len());
    send_sample(2'd1, 16'h0000, 28'h0010000, idle_len());     // one rps error: full duty
    drain_results();

    // Directed: largest integral gain drives the integrator into both rails.
    load_gains(24'h010000, 24'h7FFFFF, 32'h0000_2000, mmpid_pkg::SPEED_SCALE_RST,
               mmpid_pkg::DUTY_FS_RST);
    repeat (3) send_sample(2'd2, 16'h8000, 28'h7FFFFFF, idle_len());
    repeat (3) send_sample(2'd3, 16'h7FFF, 28'h8000000, idle_len());
    send_sample(2'd2, 16'h0000, 28'h0000000, idle_len());
    send_sample(2'd3, 16'h0000, 28'h0000000, idle_len());
    drain_results();

    // Random phases, each with its own register setting; the first two are the
    // extremes, the last returns to the reset scale and full range.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          kp = 24'h7FFFFF; ki = 24'h7FFFFF; kd = 32'h7FFF_FFFF;
          scale = 24'hFFFFFF; full_scale = 8'd255;
        end
        1: begin
          kp = 24'h800000; ki = 24'h800000; kd = 32'h8000_0000;
          scale = 24'h000000; full_scale = 8'd0;
        end
        7: begin
          kp = 24'(signed_spread(1 << 18)); ki = 24'h000000; kd = 32'h0000_0000;
          scale = mmpid_pkg::SPEED_SCALE_RST; full_scale = mmpid_pkg::DUTY_FS_RST;
        end
        default: begin
          kp = 24'(signed_spread(1 << 18));
          ki = 24'(signed_spread(1 << 13));
          kd = 32'(signed_spread(1 << 20));
          scale = (ph % 2 == 1) ? 24'($urandom) : 24'($urandom_range(1 << 18, 1 << 22));
          full_scale = 8'($urandom);
        end
      endcase
      load_gains(kp, ki, kd, scale, full_scale);
      calm = (ph == 3 || ph == 6);
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Phase two: request the long sink hold-off and keep offering back to
        // back so the block backs up into its input.
        if (ph == 2 && k == 20) hold_off_req = 1'b1;
        gap = (ph == 2 && k >= 20 && k < 60) ? 0 : idle_len();
        send_random_sample(gap);
      end
      drain_results();
    end
    calm = 1'b0;

    // Let any stray beat surface before the verdict.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> multi_motor_pid_speed_control.f
hdl/mmpid_pkg.sv
hdl/multi_motor_pid_speed_control.sv
tb/mmpid_checker.sv
tb/tb.sv
